FILE: src/arrival_steering_defines.svh
// ----------------------------------------------------------------------------
// arrival steering assertion macros
// shared property shapes for the port checker
// ----------------------------------------------------------------------------
`ifndef ARRIVAL_STEERING_DEFINES_SVH
`define ARRIVAL_STEERING_DEFINES_SVH

// same-cycle implication, held off during reset
`define AST_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("arrival steering check failed");

// next-cycle implication, held off during reset
`define AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("arrival steering check failed");

`endif

FILE: src/ast_pkg.sv
// ----------------------------------------------------------------------------
// ast_pkg
// shared types and constants of the arrival steering block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ast_pkg;

    localparam int V_BITS   = 16;
    localparam int R_BITS   = 23;
    localparam int OUT_BITS = 17;
    localparam int QB       = 16;

    localparam logic [V_BITS-1:0] MAX_VEL_RESET  = 16'd2560;
    localparam logic [R_BITS-1:0] SLOW_RAD_RESET = 23'd25600;

    localparam logic [0:0] REG_MAX_VEL  = 1'b0;
    localparam logic [0:0] REG_SLOW_RAD = 1'b1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    typedef struct packed {
        logic [V_BITS-1:0] max_vel;
        logic [R_BITS-1:0] slow_rad;
    } t_cfg;

    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic zero;
        logic in_radius;
    } t_flags;

endpackage

`default_nettype wire

FILE: src/arrival_steering.sv
// ----------------------------------------------------------------------------
// arrival_steering
// arrival steering vector from target and position, with register port
// ----------------------------------------------------------------------------
// Takes one item per cycle while the queue has room and delivers one result per
// cycle while the output is not stalled. Items pass 4 front stages, the queue,
// min(COORD_BITS+2, 32) root stages, 16 divide stages and 1 output register; the
// root and divider stages each produce one bit. A 4-entry queue sits between front and back so a
// stalled output does not halt input until the queue fills. Registers:
// max_velocity at 0x0, slowing_radius at 0x4; write them only while idle.
`timescale 1ns / 1ps
`default_nettype none

module arrival_steering #(
    parameter int COORD_BITS = 24
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_in_valid,
    output logic                          o_in_ready,
    input  wire logic signed [COORD_BITS-1:0] i_target_x,
    input  wire logic signed [COORD_BITS-1:0] i_target_y,
    input  wire logic signed [COORD_BITS-1:0] i_position_x,
    input  wire logic signed [COORD_BITS-1:0] i_position_y,
    output logic                          o_out_valid,
    input  wire                           i_out_ready,
    output logic signed [16:0]            o_steer_x,
    output logic signed [16:0]            o_steer_y,
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire [2:0]                     paddr,
    input  wire [31:0]                    pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int D  = COORD_BITS + 1;
    localparam int AB = (D > 31) ? 31 : D;
    localparam int SW = 2 * AB + 1;
    localparam int NW = AB + ast_pkg::V_BITS;
    localparam int JW = 4 + SW + 2 * NW;

    ast_pkg::t_cfg r_cfg;
    logic          wr;
    logic          push, full, q_valid, pop;
    logic [JW-1:0] f_job, q_job;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_vel  <= ast_pkg::MAX_VEL_RESET;
            r_cfg.slow_rad <= ast_pkg::SLOW_RAD_RESET;
        end else if (wr) begin
            case (paddr[2])
                ast_pkg::REG_MAX_VEL:  r_cfg.max_vel  <= pwdata[ast_pkg::V_BITS-1:0];
                ast_pkg::REG_SLOW_RAD: r_cfg.slow_rad <= pwdata[ast_pkg::R_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            ast_pkg::REG_MAX_VEL:  prdata = 32'(r_cfg.max_vel);
            ast_pkg::REG_SLOW_RAD: prdata = 32'(r_cfg.slow_rad);
            default:               prdata = '0;
        endcase
    end

    ast_front #(.COORD_BITS(COORD_BITS), .JW(JW)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_tx    (i_target_x),
        .i_ty    (i_target_y),
        .i_px    (i_position_x),
        .i_py    (i_position_y),
        .i_cfg   (r_cfg),
        .o_push  (push),
        .i_full  (full),
        .o_job   (f_job)
    );

    ast_fifo #(.W(JW)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (f_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_job)
    );

    ast_back #(.COORD_BITS(COORD_BITS), .JW(JW)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_pop   (pop),
        .i_job   (q_job),
        .i_cfg   (r_cfg),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_sx    (o_steer_x),
        .o_sy    (o_steer_y)
    );

endmodule

`default_nettype wire

FILE: src/ast_front.sv
// ----------------------------------------------------------------------------
// ast_front
// difference, magnitude, squares, numerators and slowing-radius test
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ast_front #(
    parameter int COORD_BITS = 24,
    parameter int JW = 4
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire logic signed [COORD_BITS-1:0] i_tx,
    input  wire logic signed [COORD_BITS-1:0] i_ty,
    input  wire logic signed [COORD_BITS-1:0] i_px,
    input  wire logic signed [COORD_BITS-1:0] i_py,
    input  wire ast_pkg::t_cfg           i_cfg,
    output logic                         o_push,
    input  wire                          i_full,
    output logic [JW-1:0]                o_job
);

    localparam int D    = COORD_BITS + 1;
    localparam int AB   = (D > 31) ? 31 : D;
    localparam int KMAX = (D > 31) ? D - 31 : 0;
    localparam int SW   = 2 * AB + 1;
    localparam int NW   = AB + ast_pkg::V_BITS;
    localparam int RRW  = 2 * ast_pkg::R_BITS;
    localparam int CMPW = (SW > RRW) ? SW : RRW;

    logic en;
    logic [3:0] r_v;

    // stage 1
    logic [D-1:0] r_ax, r_ay;
    logic         r_nx1, r_ny1;
    // stage 2
    logic [AB-1:0] r_a, r_b;
    logic          r_k0_2, r_zero2, r_nx2, r_ny2;
    // stage 3
    logic [2*AB-1:0] r_aa, r_bb;
    logic [RRW-1:0]  r_rr;
    logic [NW-1:0]   r_na3, r_nb3;
    logic            r_k0_3, r_zero3, r_nx3, r_ny3;
    // stage 4
    logic [SW-1:0]   r_sum;
    logic [NW-1:0]   r_na4, r_nb4;
    ast_pkg::t_flags r_flags;

    logic signed [D-1:0] dx, dy;
    logic [D-1:0] n_ax, n_ay, m;
    logic [1:0]   kk;

    assign en      = !r_v[3] || !i_full;
    assign o_ready = en;
    assign o_push  = r_v[3] && !i_full;
    assign o_job   = {r_flags, r_sum, r_na4, r_nb4};

    always_comb begin
        dx   = D'(i_tx) - D'(i_px);
        dy   = D'(i_ty) - D'(i_py);
        n_ax = dx[D-1] ? D'(~dx + 1'b1) : D'(dx);
        n_ay = dy[D-1] ? D'(~dy + 1'b1) : D'(dy);
    end

    // smallest shift that brings the larger magnitude below 2^31
    always_comb begin
        m  = (r_ax > r_ay) ? r_ax : r_ay;
        kk = 2'(KMAX);
        for (int k = KMAX; k >= 0; k--) begin
            if (((m >> k) >> 31) == '0) begin
                kk = 2'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ax  <= n_ax;
            r_ay  <= n_ay;
            r_nx1 <= dx[D-1];
            r_ny1 <= dy[D-1];

            r_a     <= AB'(r_ax >> kk);
            r_b     <= AB'(r_ay >> kk);
            r_k0_2  <= (kk == 2'd0);
            r_zero2 <= (r_ax == '0) && (r_ay == '0);
            r_nx2   <= r_nx1;
            r_ny2   <= r_ny1;

            r_aa    <= (2*AB)'(r_a) * (2*AB)'(r_a);
            r_bb    <= (2*AB)'(r_b) * (2*AB)'(r_b);
            r_rr    <= RRW'(i_cfg.slow_rad) * RRW'(i_cfg.slow_rad);
            r_na3   <= NW'(r_a) * NW'(i_cfg.max_vel);
            r_nb3   <= NW'(r_b) * NW'(i_cfg.max_vel);
            r_k0_3  <= r_k0_2;
            r_zero3 <= r_zero2;
            r_nx3   <= r_nx2;
            r_ny3   <= r_ny2;

            r_sum             <= SW'(r_aa) + SW'(r_bb);
            r_na4             <= r_na3;
            r_nb4             <= r_nb3;
            r_flags.neg_x     <= r_nx3;
            r_flags.neg_y     <= r_ny3;
            r_flags.zero      <= r_zero3;
            r_flags.in_radius <= r_k0_3 && (CMPW'(SW'(r_aa) + SW'(r_bb)) < CMPW'(r_rr));
        end
    end

endmodule

`default_nettype wire

FILE: src/ast_fifo.sv
// ----------------------------------------------------------------------------
// ast_fifo
// short queue that decouples the classifying front from the arithmetic back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ast_fifo #(
    parameter int W = 8
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_push,
    input  wire [W-1:0]  i_data,
    output logic         o_full,
    input  wire          i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_mem [ast_pkg::FIFO_DEPTH];
    logic [ast_pkg::FIFO_AW-1:0] r_wr, r_rd;
    logic [ast_pkg::FIFO_AW:0]   r_cnt;
    logic do_push, do_pop;

    assign o_full  = (r_cnt == (ast_pkg::FIFO_AW+1)'(ast_pkg::FIFO_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

FILE: src/ast_back.sv
// ----------------------------------------------------------------------------
// ast_back
// pipelined square root, two pipelined dividers and saturating output stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ast_back #(
    parameter int COORD_BITS = 24,
    parameter int JW = 4
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_pop,
    input  wire [JW-1:0]        i_job,
    input  wire ast_pkg::t_cfg  i_cfg,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic signed [ast_pkg::OUT_BITS-1:0] o_sx,
    output logic signed [ast_pkg::OUT_BITS-1:0] o_sy
);

    localparam int D   = COORD_BITS + 1;
    localparam int AB  = (D > 31) ? 31 : D;
    localparam int SW  = 2 * AB + 1;
    localparam int NW  = AB + ast_pkg::V_BITS;
    localparam int SQN = AB + 1;
    localparam int SQW = SW + 1;
    localparam int QB  = ast_pkg::QB;
    localparam int DW  = (SQN > ast_pkg::R_BITS) ? SQN : ast_pkg::R_BITS;
    localparam int CW  = DW + QB;

    typedef struct packed {
        ast_pkg::t_flags flags;
        logic [SQW-1:0]  v;
        logic [SQW-1:0]  r;
        logic [NW-1:0]   na;
        logic [NW-1:0]   nb;
    } t_sq;

    typedef struct packed {
        ast_pkg::t_flags flags;
        logic [DW-1:0]   dv;
        logic [CW-1:0]   rx;
        logic [CW-1:0]   ry;
        logic [QB-1:0]   qx;
        logic [QB-1:0]   qy;
    } t_dv;

    ast_pkg::t_flags in_flags;
    logic [SW-1:0]   in_sum;
    logic [NW-1:0]   in_na, in_nb;

    logic en;
    logic [SQN-1:0] r_sqv;
    logic [QB-1:0]  r_dvv;
    t_sq r_sq [SQN];
    t_dv r_dv [QB];
    t_sq sq_in [SQN];
    t_sq sq_out [SQN];
    t_dv dv_in [QB];
    t_dv dv_out [QB];
    logic [SQW-1:0] sq_bit [SQN];
    logic [SQW-1:0] sq_try [SQN];
    logic [CW-1:0]  dv_try [QB];

    logic r_out_v;
    logic signed [ast_pkg::OUT_BITS-1:0] r_sx, r_sy;
    logic [QB-1:0] mag_x, mag_y;
    t_dv last;

    assign {in_flags, in_sum, in_na, in_nb} = i_job;
    assign en      = !r_out_v || i_ready;
    assign o_pop   = en && i_valid;
    assign o_valid = r_out_v;
    assign o_sx    = r_sx;
    assign o_sy    = r_sy;

    // one root bit per stage
    always_comb begin
        for (int s = 0; s < SQN; s++) begin
            if (s == 0) begin
                sq_in[s].flags = in_flags;
                sq_in[s].v     = SQW'(in_sum);
                sq_in[s].r     = '0;
                sq_in[s].na    = in_na;
                sq_in[s].nb    = in_nb;
            end else begin
                sq_in[s] = r_sq[s-1];
            end
            sq_bit[s] = SQW'(1) << (2 * (SQN - 1 - s));
            sq_try[s] = sq_in[s].r + sq_bit[s];
            sq_out[s] = sq_in[s];
            if (sq_in[s].v >= sq_try[s]) begin
                sq_out[s].v = sq_in[s].v - sq_try[s];
                sq_out[s].r = (sq_in[s].r >> 1) + sq_bit[s];
            end else begin
                sq_out[s].r = sq_in[s].r >> 1;
            end
        end
    end

    // one quotient bit per stage; the output stage clamps the quotient to max velocity
    always_comb begin
        for (int j = 0; j < QB; j++) begin
            if (j == 0) begin
                dv_in[j].flags = r_sq[SQN-1].flags;
                dv_in[j].dv    = r_sq[SQN-1].flags.in_radius ? DW'(i_cfg.slow_rad)
                                                             : DW'(r_sq[SQN-1].r);
                dv_in[j].rx    = CW'(r_sq[SQN-1].na);
                dv_in[j].ry    = CW'(r_sq[SQN-1].nb);
                dv_in[j].qx    = '0;
                dv_in[j].qy    = '0;
            end else begin
                dv_in[j] = r_dv[j-1];
            end
            dv_try[j] = CW'(dv_in[j].dv) << (QB - 1 - j);
            dv_out[j] = dv_in[j];
            if (dv_in[j].rx >= dv_try[j]) begin
                dv_out[j].rx            = dv_in[j].rx - dv_try[j];
                dv_out[j].qx[QB - 1 - j] = 1'b1;
            end
            if (dv_in[j].ry >= dv_try[j]) begin
                dv_out[j].ry            = dv_in[j].ry - dv_try[j];
                dv_out[j].qy[QB - 1 - j] = 1'b1;
            end
        end
    end

    always_comb begin
        last  = r_dv[QB-1];
        mag_x = (last.qx > i_cfg.max_vel) ? i_cfg.max_vel : last.qx;
        mag_y = (last.qy > i_cfg.max_vel) ? i_cfg.max_vel : last.qy;
        if (last.flags.zero) begin
            mag_x = '0;
            mag_y = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sqv   <= '0;
            r_dvv   <= '0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_sqv   <= {r_sqv[SQN-2:0], i_valid};
            r_dvv   <= {r_dvv[QB-2:0], r_sqv[SQN-1]};
            r_out_v <= r_dvv[QB-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int s = 0; s < SQN; s++) begin
                r_sq[s] <= sq_out[s];
            end
            for (int j = 0; j < QB; j++) begin
                r_dv[j] <= dv_out[j];
            end
            r_sx <= last.flags.neg_x ? -$signed({1'b0, mag_x}) : $signed({1'b0, mag_x});
            r_sy <= last.flags.neg_y ? -$signed({1'b0, mag_y}) : $signed({1'b0, mag_y});
        end
    end

endmodule

`default_nettype wire

FILE: src/ast_chk.sv
// ----------------------------------------------------------------------------
// ast_chk
// port-level checks of the arrival steering block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "arrival_steering_defines.svh"

module ast_chk (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_out_valid,
    input wire        i_out_ready,
    input wire [16:0] o_steer_x,
    input wire [16:0] o_steer_y,
    input wire        pready
);

    `AST_IMPL(a_pready_high, 1'b1, pready)
    `AST_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_steer_x) && $stable(o_steer_y))
    // magnitudes are clamped to a 16-bit speed, so the most negative code never shows
    `AST_IMPL(a_no_min_code, o_out_valid, (o_steer_x != 17'h10000) && (o_steer_y != 17'h10000))

endmodule

bind arrival_steering ast_chk u_ast_chk (.*);

`default_nettype wire
